// ===== src/adaptive_sampling_escalation_fsm_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive sampling escalation block
// Concurrent property wrappers sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_SAMPLING_ESCALATION_FSM_ASSERT_SVH
`define ADAPTIVE_SAMPLING_ESCALATION_FSM_ASSERT_SVH

// same-cycle implication
`define ASEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/asef_pkg.sv =====
// ----------------------------------------------------------------------------
// asef_pkg
// Types, register indexes and helpers for the sampling escalation machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asef_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SUSPECT    = 3'd1,
    MODE_DIAGNOSTIC = 3'd2,
    MODE_PROFILING  = 3'd3,
    MODE_COOLDOWN   = 3'd4
  } mode_t;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUSPECT_SCORE     = 4'd0,
    CFG_DIAGNOSTIC_SCORE  = 4'd1,
    CFG_PROFILING_SCORE   = 4'd2,
    CFG_RECOVERY_SCORE    = 4'd3,
    CFG_SUSPECT_RUN       = 4'd4,
    CFG_DIAGNOSTIC_RUN    = 4'd5,
    CFG_PROFILING_LIMIT   = 4'd6,
    CFG_COOLDOWN          = 4'd7
  } cfg_idx_t;

  localparam logic [31:0] MS_PER_SEC = 32'd1000;

  localparam logic [15:0] RST_SUSPECT_SCORE    = 16'd32768;
  localparam logic [15:0] RST_DIAGNOSTIC_SCORE = 16'd45875;
  localparam logic [15:0] RST_PROFILING_SCORE  = 16'd55705;
  localparam logic [15:0] RST_RECOVERY_SCORE   = 16'd19660;
  localparam logic [7:0]  RST_SUSPECT_RUN      = 8'd3;
  localparam logic [7:0]  RST_DIAGNOSTIC_RUN   = 8'd3;
  localparam logic [31:0] RST_PROFILING_MS     = 32'd30000;
  localparam logic [31:0] RST_COOLDOWN_MS      = 32'd60000;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

endpackage

// ===== src/adaptive_sampling_escalation_fsm.sv =====
// ----------------------------------------------------------------------------
// Adaptive sampling escalation machine
// Five-mode escalation driven by one scored sample per word: runs of high
// scores raise the mode, runs of recovery scores lower it, profiling and
// cooldown are bounded by millisecond windows.
// ----------------------------------------------------------------------------
// Takes one sample word per clock unless the result side stalls, and returns
// one result word per sample: the accepting edge registers the sample in the
// input register, and when that register moves on, the mode, run counters and
// window start times update together from it and load the result register.
// The state thus keeps pace with one sample per clock while unstalled;
// backpressure on the result side holds the result register and, once the
// input register is also full, the input. Window limits are kept in
// milliseconds, converted from seconds when the configuration is written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adaptive_sampling_escalation_fsm_assert.svh"

module adaptive_sampling_escalation_fsm
  import asef_pkg::*;
#(
  parameter int RECOVERY_RUN_NEEDED = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          in_score,
  input  logic                 in_profile_wanted,
  input  logic [31:0]          in_now_ms,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_mode,
  output logic                 out_mode_changed
);

  localparam logic [7:0] RecoverNeed = 8'(RECOVERY_RUN_NEEDED);

  logic [15:0] suspect_score_r;
  logic [15:0] diagnostic_score_r;
  logic [15:0] profiling_score_r;
  logic [15:0] recovery_score_r;
  logic [7:0]  suspect_run_r;
  logic [7:0]  diagnostic_run_r;
  logic [31:0] profiling_ms_r;
  logic [31:0] cooldown_ms_r;

  logic        s1_valid_r;
  logic [15:0] s1_score_r;
  logic        s1_want_r;
  logic [31:0] s1_now_r;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  high_run_r, high_run_nxt;
  logic [7:0]  diag_run_r, diag_run_nxt;
  logic [7:0]  rec_run_r, rec_run_nxt;
  logic [31:0] prof_start_r, prof_start_nxt;
  logic [31:0] cool_start_r, cool_start_nxt;

  logic        out_valid_r;
  logic [2:0]  out_mode_r;
  logic        out_changed_r;

  logic        advance;
  logic        fire;
  logic        enter;
  mode_t       target;
  logic        rec;
  logic [7:0]  rec_inc;
  logic [7:0]  diag_step;
  logic        prof_done;
  logic        cool_done;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign fire     = s1_valid_r && advance;

  assign out_valid        = out_valid_r;
  assign out_mode         = out_mode_r;
  assign out_mode_changed = out_changed_r;

  // configuration; window limits stored in ms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suspect_score_r    <= RST_SUSPECT_SCORE;
      diagnostic_score_r <= RST_DIAGNOSTIC_SCORE;
      profiling_score_r  <= RST_PROFILING_SCORE;
      recovery_score_r   <= RST_RECOVERY_SCORE;
      suspect_run_r      <= RST_SUSPECT_RUN;
      diagnostic_run_r   <= RST_DIAGNOSTIC_RUN;
      profiling_ms_r     <= RST_PROFILING_MS;
      cooldown_ms_r      <= RST_COOLDOWN_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SUSPECT_SCORE:    suspect_score_r    <= cfg_data;
        CFG_DIAGNOSTIC_SCORE: diagnostic_score_r <= cfg_data;
        CFG_PROFILING_SCORE:  profiling_score_r  <= cfg_data;
        CFG_RECOVERY_SCORE:   recovery_score_r   <= cfg_data;
        CFG_SUSPECT_RUN:      suspect_run_r      <= cfg_data[7:0];
        CFG_DIAGNOSTIC_RUN:   diagnostic_run_r   <= cfg_data[7:0];
        CFG_PROFILING_LIMIT:  profiling_ms_r     <= 32'(cfg_data) * MS_PER_SEC;
        CFG_COOLDOWN:         cooldown_ms_r      <= 32'(cfg_data) * MS_PER_SEC;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_score_r <= in_score;
      s1_want_r  <= in_profile_wanted;
      s1_now_r   <= in_now_ms;
    end
  end

  assign rec       = s1_score_r <= recovery_score_r;
  assign rec_inc   = sat_inc(rec_run_r);
  assign diag_step = (s1_score_r >= diagnostic_score_r) ? sat_inc(diag_run_r) : 8'd0;
  assign prof_done = (s1_now_r - prof_start_r) >= profiling_ms_r;
  assign cool_done = (s1_now_r - cool_start_r) >= cooldown_ms_r;

  always_comb begin
    mode_nxt       = mode_r;
    high_run_nxt   = high_run_r;
    diag_run_nxt   = diag_run_r;
    rec_run_nxt    = rec_run_r;
    prof_start_nxt = prof_start_r;
    cool_start_nxt = cool_start_r;
    enter          = 1'b0;
    target         = mode_r;

    case (mode_r)
      MODE_NORMAL: begin
        if (s1_score_r >= suspect_score_r) begin
          high_run_nxt = sat_inc(high_run_r);
          if (high_run_nxt >= suspect_run_r) begin
            enter  = 1'b1;
            target = MODE_SUSPECT;
          end
        end else begin
          high_run_nxt = 8'd0;
        end
      end
      MODE_SUSPECT: begin
        if (rec) begin
          rec_run_nxt = rec_inc;
          if (rec_inc >= RecoverNeed) begin
            enter  = 1'b1;
            target = MODE_NORMAL;
          end
        end else begin
          rec_run_nxt  = 8'd0;
          diag_run_nxt = diag_step;
          if (diag_step >= diagnostic_run_r) begin
            enter  = 1'b1;
            target = MODE_DIAGNOSTIC;
          end
        end
      end
      MODE_DIAGNOSTIC: begin
        if (rec) begin
          rec_run_nxt = rec_inc;
          if (rec_inc >= RecoverNeed) begin
            enter  = 1'b1;
            target = MODE_COOLDOWN;
          end
        end else begin
          rec_run_nxt = 8'd0;
          if (s1_want_r && s1_score_r >= profiling_score_r) begin
            enter  = 1'b1;
            target = MODE_PROFILING;
          end
        end
      end
      MODE_PROFILING: begin
        if (prof_done || rec) begin
          enter  = 1'b1;
          target = MODE_COOLDOWN;
        end else begin
          rec_run_nxt = 8'd0;
        end
      end
      MODE_COOLDOWN: begin
        if (rec) begin
          rec_run_nxt = rec_inc;
          if (cool_done && rec_inc >= RecoverNeed) begin
            enter  = 1'b1;
            target = MODE_NORMAL;
          end
        end else if (!cool_done) begin
          rec_run_nxt  = 8'd0;
          diag_run_nxt = 8'd0;
        end else begin
          rec_run_nxt  = 8'd0;
          diag_run_nxt = diag_step;
          if (diag_step >= diagnostic_run_r) begin
            enter  = 1'b1;
            target = MODE_DIAGNOSTIC;
          end
        end
      end
      default: ;
    endcase

    if (enter) begin
      mode_nxt     = target;
      high_run_nxt = 8'd0;
      diag_run_nxt = 8'd0;
      rec_run_nxt  = 8'd0;
      if (target == MODE_PROFILING) begin
        prof_start_nxt = s1_now_r;
      end
      if (target == MODE_COOLDOWN) begin
        cool_start_nxt = s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NORMAL;
      high_run_r   <= 8'd0;
      diag_run_r   <= 8'd0;
      rec_run_r    <= 8'd0;
      prof_start_r <= 32'd0;
      cool_start_r <= 32'd0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      high_run_r   <= high_run_nxt;
      diag_run_r   <= diag_run_nxt;
      rec_run_r    <= rec_run_nxt;
      prof_start_r <= prof_start_nxt;
      cool_start_r <= cool_start_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_mode_r    <= 3'(mode_nxt);
      out_changed_r <= (mode_nxt != mode_r);
    end
  end

  `ASEF_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_ready, "input stalled with empty result")
  `ASEF_ASSERT_NOW(a_out_tracks_mode, out_valid_r, out_mode_r == 3'(mode_r), "result mode mismatch")
  `ASEF_ASSERT_NEXT(a_entry_clears_runs, fire && enter,
    high_run_r == 8'd0 && diag_run_r == 8'd0 && rec_run_r == 8'd0, "runs not cleared on entry")
  `ASEF_ASSERT_NEXT(a_prof_start_load, fire && enter && target == MODE_PROFILING,
    prof_start_r == $past(s1_now_r), "profiling start not loaded")

endmodule

// ===== tb/adaptive_sampling_escalation_fsm_tb.sv =====
// ----------------------------------------------------------------------------
// adaptive_sampling_escalation_fsm_tb
// Drives scored sample words through the escalation machine and compares
// each result word with a cycle-free predictor of the mode machine, or, for
// typed directed rows, with the row's own word. It runs a directed table first
// and then phases of random runs under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adaptive_sampling_escalation_fsm_tb;
  import asef_pkg::*;

  localparam int RECOVERY_RUNS = 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PCT      = 6;
  localparam int DIR_ROWS      = 27;

  typedef struct packed {
    mode_t mode;
    logic  changed;
  } mode_word_t;

  typedef struct packed {
    logic [15:0] score;
    logic        want;
    logic [31:0] now;
    logic        typed;
    mode_t       mode;
    logic        changed;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [15:0]          in_score;
  logic                 in_profile_wanted;
  logic [31:0]          in_now_ms;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_mode;
  logic                 out_mode_changed;

  // predictor registers and state
  logic [15:0] thr_suspect, thr_diag, thr_prof, thr_recov;
  logic [7:0]  run_suspect, run_diag;
  logic [31:0] prof_limit_ms, cool_ms;
  mode_t       cur_mode;
  logic [7:0]  hi_cnt, dg_cnt, rc_cnt;
  logic [31:0] prof_t0, cool_t0;

  mode_word_t  pending_modes[$];
  logic        row_typed;
  mode_t       row_mode;
  logic        row_changed;
  bit          calm;
  int          errors;
  int          cycles;
  logic [31:0] stamp_ms;
  stim_row_t   dir_rows [DIR_ROWS];

  adaptive_sampling_escalation_fsm #(
    .RECOVERY_RUN_NEEDED (RECOVERY_RUNS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_score          (in_score),
    .in_profile_wanted (in_profile_wanted),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mode          (out_mode),
    .out_mode_changed  (out_mode_changed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] count_up(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  task automatic track_escalation(input logic [15:0] sc, input logic want,
                                  input logic [31:0] now, output mode_word_t res);
    mode_t       nxt;
    logic        recov;
    logic        done;
    logic [31:0] elapsed;
    nxt   = cur_mode;
    recov = (sc <= thr_recov);
    case (cur_mode)
      MODE_NORMAL: begin
        if (sc >= thr_suspect) begin
          hi_cnt = count_up(hi_cnt);
          if (hi_cnt >= run_suspect) nxt = MODE_SUSPECT;
        end else begin
          hi_cnt = 8'd0;
        end
      end
      MODE_SUSPECT: begin
        rc_cnt = recov ? count_up(rc_cnt) : 8'd0;
        if (recov) begin
          if (rc_cnt >= RECOVERY_RUNS) nxt = MODE_NORMAL;
        end else begin
          dg_cnt = (sc >= thr_diag) ? count_up(dg_cnt) : 8'd0;
          if (dg_cnt >= run_diag) nxt = MODE_DIAGNOSTIC;
        end
      end
      MODE_DIAGNOSTIC: begin
        rc_cnt = recov ? count_up(rc_cnt) : 8'd0;
        if (recov) begin
          if (rc_cnt >= RECOVERY_RUNS) nxt = MODE_COOLDOWN;
        end else if (want && sc >= thr_prof) begin
          nxt = MODE_PROFILING;
        end
      end
      MODE_PROFILING: begin
        elapsed = now - prof_t0;
        if (elapsed >= prof_limit_ms) begin
          nxt = MODE_COOLDOWN;
        end else begin
          rc_cnt = recov ? count_up(rc_cnt) : 8'd0;
          if (recov) nxt = MODE_COOLDOWN;
        end
      end
      MODE_COOLDOWN: begin
        elapsed = now - cool_t0;
        done    = (elapsed >= cool_ms);
        rc_cnt  = recov ? count_up(rc_cnt) : 8'd0;
        if (recov) begin
          if (done && rc_cnt >= RECOVERY_RUNS) nxt = MODE_NORMAL;
        end else if (!done) begin
          dg_cnt = 8'd0;
        end else begin
          dg_cnt = (sc >= thr_diag) ? count_up(dg_cnt) : 8'd0;
          if (dg_cnt >= run_diag) nxt = MODE_DIAGNOSTIC;
        end
      end
      default: ;
    endcase
    res.changed = (nxt != cur_mode);
    if (nxt != cur_mode) begin
      hi_cnt = 8'd0;
      dg_cnt = 8'd0;
      rc_cnt = 8'd0;
      if (nxt == MODE_PROFILING) prof_t0 = now;
      if (nxt == MODE_COOLDOWN)  cool_t0 = now;
    end
    cur_mode = nxt;
    res.mode = nxt;
  endtask

  always @(posedge clk) begin : score_chk
    mode_word_t exp_w;
    mode_word_t calc_w;
    if (!rst_n) begin
      thr_suspect   = RST_SUSPECT_SCORE;
      thr_diag      = RST_DIAGNOSTIC_SCORE;
      thr_prof      = RST_PROFILING_SCORE;
      thr_recov     = RST_RECOVERY_SCORE;
      run_suspect   = RST_SUSPECT_RUN;
      run_diag      = RST_DIAGNOSTIC_RUN;
      prof_limit_ms = RST_PROFILING_MS;
      cool_ms       = RST_COOLDOWN_MS;
      cur_mode      = MODE_NORMAL;
      hi_cnt        = 8'd0;
      dg_cnt        = 8'd0;
      rc_cnt        = 8'd0;
      prof_t0       = 32'd0;
      cool_t0       = 32'd0;
      pending_modes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_modes.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, mode %0d changed %0d", $time, out_mode,
                   out_mode_changed);
        end else begin
          exp_w = pending_modes.pop_front();
          if (out_mode !== exp_w.mode) begin
            errors++;
            $display("%0t: mode expected %0d actual %0d", $time, exp_w.mode, out_mode);
          end
          if (out_mode_changed !== exp_w.changed) begin
            errors++;
            $display("%0t: mode_changed expected %0d actual %0d", $time, exp_w.changed,
                     out_mode_changed);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SUSPECT_SCORE:    thr_suspect   = cfg_data;
          CFG_DIAGNOSTIC_SCORE: thr_diag      = cfg_data;
          CFG_PROFILING_SCORE:  thr_prof      = cfg_data;
          CFG_RECOVERY_SCORE:   thr_recov     = cfg_data;
          CFG_SUSPECT_RUN:      run_suspect   = cfg_data[7:0];
          CFG_DIAGNOSTIC_RUN:   run_diag      = cfg_data[7:0];
          CFG_PROFILING_LIMIT:  prof_limit_ms = {16'd0, cfg_data} * MS_PER_SEC;
          CFG_COOLDOWN:         cool_ms       = {16'd0, cfg_data} * MS_PER_SEC;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        track_escalation(in_score, in_profile_wanted, in_now_ms, calc_w);
        if (row_typed) begin
          exp_w.mode    = row_mode;
          exp_w.changed = row_changed;
          pending_modes.push_back(exp_w);
        end else begin
          pending_modes.push_back(calc_w);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

  task automatic put_word(input logic [15:0] sc, input logic want, input logic [31:0] now,
                          input logic typed, input mode_t m, input logic chg);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_score          <= sc;
    in_profile_wanted <= want;
    in_now_ms         <= now;
    row_typed          = typed;
    row_mode           = m;
    row_changed        = chg;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_modes.size() != 0) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] sus, input logic [15:0] dia,
                               input logic [15:0] pro, input logic [15:0] rec,
                               input logic [7:0] srun, input logic [7:0] drun,
                               input logic [15:0] plim, input logic [15:0] cool);
    drain();
    program_reg(CFG_SUSPECT_SCORE, sus);
    program_reg(CFG_DIAGNOSTIC_SCORE, dia);
    program_reg(CFG_PROFILING_SCORE, pro);
    program_reg(CFG_RECOVERY_SCORE, rec);
    program_reg(CFG_SUSPECT_RUN, {8'($urandom), srun});
    program_reg(CFG_DIAGNOSTIC_RUN, {8'($urandom), drun});
    program_reg(CFG_PROFILING_LIMIT, plim);
    program_reg(CFG_COOLDOWN, cool);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_burst(input int count);
    int          sent;
    int          cat;
    int          len;
    int          j;
    logic [15:0] sc;
    logic        wnt;
    logic [31:0] step;
    step = (prof_limit_ms >> 2) + (cool_ms >> 2) + 32'd50;
    sent = 0;
    while (sent < count) begin
      cat = $urandom_range(0, 9);
      len = $urandom_range(1, 6);
      for (j = 0; j < len && sent < count; j++) begin
        case (cat)
          0, 1:    sc = 16'($urandom_range(0, thr_recov));
          2, 3:    sc = 16'($urandom_range(thr_suspect, 16'hffff));
          4, 5:    sc = 16'($urandom_range(thr_diag, 16'hffff));
          6, 7:    sc = 16'($urandom_range(thr_prof, 16'hffff));
          8:       sc = 16'($urandom_range(thr_recov, thr_suspect));
          default: sc = 16'($urandom);
        endcase
        wnt = (cat == 6 || cat == 7) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
          0:       stamp_ms = $urandom;
          1:       stamp_ms = stamp_ms - 32'($urandom_range(0, step));
          default: stamp_ms = stamp_ms + 32'($urandom_range(0, step));
        endcase
        put_word(sc, wnt, stamp_ms, 1'b0, MODE_NORMAL, 1'b0);
        sent++;
      end
    end
  endtask

  initial begin
    int          i;
    int          ph;
    logic [15:0] s_sus, s_dia, s_pro;
    logic [31:0] t0;
    errors            = 0;
    calm              = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SUSPECT_SCORE;
    cfg_data          = 16'd0;
    in_valid          = 1'b0;
    in_score          = 16'd0;
    in_profile_wanted = 1'b0;
    in_now_ms         = 32'd0;
    out_ready         = 1'b1;
    row_typed         = 1'b0;
    row_mode          = MODE_NORMAL;
    row_changed       = 1'b0;
    dir_rows = '{
      '{16'h0000, 1'b0, 32'd1000,      1'b1, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b1, 32'd1010,      1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b0, 32'd1020,      1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b0, 32'd1030,      1'b1, MODE_SUSPECT,    1'b1},
      '{16'h0000, 1'b0, 32'd1040,      1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b0, 32'd1050,      1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b1, 32'd1060,      1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b0, 32'd1070,      1'b1, MODE_DIAGNOSTIC, 1'b1},
      '{16'hffff, 1'b1, 32'd2000,      1'b1, MODE_PROFILING,  1'b1},
      '{16'd40000, 1'b0, 32'd31999,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd40000, 1'b1, 32'd32000,    1'b1, MODE_COOLDOWN,   1'b1},
      '{16'h0000, 1'b0, 32'd33000,     1'b0, MODE_NORMAL,     1'b0},
      '{16'hffff, 1'b1, 32'd33000,     1'b0, MODE_NORMAL,     1'b0},
      '{16'h0000, 1'b0, 32'd92000,     1'b0, MODE_NORMAL,     1'b0},
      '{16'd19660, 1'b0, 32'd92000,    1'b0, MODE_NORMAL,     1'b0},
      '{16'h0000, 1'b0, 32'd92000,     1'b1, MODE_NORMAL,     1'b1},
      '{16'd32767, 1'b0, 32'd92100,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd32768, 1'b0, 32'd92200,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd32768, 1'b1, 32'd92300,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd32768, 1'b0, 32'd92400,    1'b1, MODE_SUSPECT,    1'b1},
      '{16'd45875, 1'b0, 32'd92500,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd45875, 1'b0, 32'd92600,    1'b0, MODE_NORMAL,     1'b0},
      '{16'd45875, 1'b0, 32'd92700,    1'b1, MODE_DIAGNOSTIC, 1'b1},
      '{16'd55704, 1'b1, 32'hffff_ffff, 1'b0, MODE_NORMAL,    1'b0},
      '{16'd55705, 1'b1, 32'hffff_ffff, 1'b1, MODE_PROFILING, 1'b1},
      '{16'd19660, 1'b0, 32'h0000_0010, 1'b1, MODE_COOLDOWN,  1'b1},
      '{16'h0000, 1'b0, 32'h0000_0005, 1'b0, MODE_NORMAL,     1'b0}
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      put_word(dir_rows[i].score, dir_rows[i].want, dir_rows[i].now,
               dir_rows[i].typed, dir_rows[i].mode, dir_rows[i].changed);
    end
    stamp_ms = 32'd5;

    // default thresholds, short windows, no idling on either side
    load_settings(16'd32768, 16'd45875, 16'd55705, 16'd19660, 8'd3, 8'd3, 16'd2, 16'd3);
    calm = 1'b1;
    random_burst(50);
    calm = 1'b0;

    // all-zero extremes, plus a write to an unmapped index
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0);
    program_reg(4'(CFG_COOLDOWN) + 4'd1 + 4'($urandom_range(0, 7)), 16'($urandom));
    cfg_we <= 1'b0;
    @(negedge clk);
    random_burst(50);

    // all-ones extremes
    load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 16'hffff, 16'hffff);
    random_burst(50);

    // hold cooldown long enough to saturate the recovery run, then release
    load_settings(16'h4000, 16'h4000, 16'h4000, 16'h1000, 8'd1, 8'd1, 16'd0, 16'hffff);
    while (cur_mode != MODE_COOLDOWN) begin
      stamp_ms = stamp_ms + 32'd10;
      put_word(16'hffff, 1'b1, stamp_ms, 1'b0, MODE_NORMAL, 1'b0);
    end
    t0 = cool_t0;
    for (i = 1; i <= 262; i++) begin
      put_word(16'($urandom_range(0, 16'h1000)), 1'($urandom_range(0, 1)), t0 + 32'(i),
               1'b0, MODE_NORMAL, 1'b0);
    end
    stamp_ms = t0 + 32'd65535000;
    put_word(16'h0000, 1'b0, stamp_ms, 1'b0, MODE_NORMAL, 1'b0);

    for (ph = 0; ph < 4; ph++) begin
      s_sus = 16'($urandom_range(20000, 50000));
      s_dia = 16'($urandom_range(s_sus, 16'hffff));
      s_pro = 16'($urandom_range(s_dia, 16'hffff));
      load_settings(s_sus, s_dia, s_pro, 16'($urandom_range(0, 30000)),
                    8'($urandom_range(0, 5)), 8'($urandom_range(0, 5)),
                    16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)));
      random_burst(50);
    end

    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                  16'($urandom), 16'($urandom));
    random_burst(50);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
